/* design/scalar_kalman_filter_bank_defines.svh */
// Assertion macros shared by the scalar Kalman filter bank RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SCALAR_KALMAN_FILTER_BANK_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_BANK_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SKFB_ASSERT_HOLDS(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SKFB_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* design/skfb_pkg.sv */
// Package for the scalar Kalman filter bank: field widths, defaults,
// register codes and the word types of both channels. No dependencies.
package skfb_pkg;

    localparam int CHANNELS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam int GAIN_BITS = 16;
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int EST_W     = 32;
    localparam int COV_W     = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;

    // Register reset values, integer part only (scaled by FRAC_BITS at use)
    localparam int NOISE_R_INIT   = 40;
    localparam int PROCESS_Q_INIT = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOISE_R   = 1'b0,
        REG_PROCESS_Q = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
    } meas_t;

    typedef struct packed {
        logic [CHAN_W-1:0]       out_channel;
        logic signed [EST_W-1:0] estimate;
        logic [GAIN_BITS-1:0]    gain;
    } filt_t;

    typedef struct packed {
        logic busy;
        logic done;
    } skfb_stat_t;

endpackage

/* design/skfb_alu.sv */
// Shared adder/subtractor of the filter core, one operation per cycle.
// Depends on nothing but its width parameter.
module skfb_alu #(
    parameter int W = 35
) (
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic                sub,
    output logic signed [W-1:0] y
);

    assign y = sub ? (a - b) : (a + b);

endmodule

/* design/skfb_core.sv */
// Filter core: per-channel estimate and covariance stores, the sequencer and
// its datapath around one shared adder. Depends on skfb_pkg and skfb_alu.
`include "scalar_kalman_filter_bank_defines.svh"

module skfb_core
    import skfb_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  meas_t            meas_in,
    input  logic [CFG_W-1:0] noise_r,
    input  logic [CFG_W-1:0] process_q,
    input  logic             take,
    output skfb_stat_t       stat,
    output filt_t            res
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int Z_W    = SAMPLE_W + FRAC_BITS;
    localparam int DIFF_W = ((Z_W > EST_W) ? Z_W : EST_W) + 1;
    localparam int SUM_W  = COV_W + 1;
    localparam int AW     = (DIFF_W + 1 > COV_W + 3) ? DIFF_W + 1 : COV_W + 3;
    localparam int CNT_W  = $clog2(GAIN_BITS + 1);
    localparam int KI_W   = $clog2(GAIN_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_SUM, S_DIV, S_DIFF, S_MULX, S_ADDX, S_MULP, S_ADDQ, S_DONE
    } state_t;

    state_t                     state_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic                       hit_reg;
    logic [EST_W-1:0]           x_rd_reg;
    logic [COV_W-1:0]           p_rd_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           rem_reg;
    logic [GAIN_BITS-1:0]       k_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [AW-1:0]       acc_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [EST_W-1:0]           nx_reg;
    filt_t                      res_reg;
    logic [CHANNELS-1:0]        vld_reg;

    logic [EST_W-1:0] est_mem [CHANNELS];
    logic [COV_W-1:0] cov_mem [CHANNELS];

    logic [IDX_W-1:0]        idx;
    logic signed [EST_W-1:0] x_cur;
    logic [COV_W-1:0]        p_cur;
    logic signed [Z_W-1:0]   z_full;
    logic [GAIN_BITS:0]      m_w;
    logic [KI_W-1:0]         kidx;
    logic signed [AW-1:0]    alu_a;
    logic signed [AW-1:0]    alu_b;
    logic                    alu_sub;
    logic signed [AW-1:0]    alu_y;
    logic                    div_take;
    logic                    est_ovf;
    logic [EST_W-1:0]        est_sat;
    logic [COV_W-1:0]        cov_sat;
    logic                    chan_ok;

    assign idx     = IDX_W'(chan_reg);
    assign chan_ok = (32'(meas_in.channel) < CHANNELS);
    assign x_cur   = hit_reg ? signed'(x_rd_reg) : '0;
    assign p_cur   = hit_reg ? p_rd_reg : '0;
    assign z_full  = {samp_reg, {FRAC_BITS{1'b0}}};
    assign m_w     = (GAIN_BITS + 1)'(1 << GAIN_BITS) - {1'b0, k_reg};
    assign kidx    = cnt_reg[KI_W-1:0];

    // Operand select for the shared adder
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_SUM:
            begin
                alu_a = AW'(p_cur);
                alu_b = AW'(noise_r);
            end
            S_DIV:
            begin
                alu_a   = AW'({rem_reg, 1'b0});
                alu_b   = AW'(sum_reg);
                alu_sub = 1'b1;
            end
            S_DIFF:
            begin
                alu_a   = AW'(z_full);
                alu_b   = AW'(x_cur);
                alu_sub = 1'b1;
            end
            S_MULX:
            begin
                alu_b = k_reg[kidx] ? AW'(diff_reg) : '0;
            end
            S_ADDX:
            begin
                alu_a = AW'(x_cur);
                alu_b = acc_reg;
            end
            S_MULP:
            begin
                alu_b = m_w[cnt_reg] ? AW'(p_cur) : '0;
            end
            S_ADDQ:
            begin
                alu_b = AW'(process_q);
            end
            default:
            begin
                alu_b = '0;
            end
        endcase
    end

    skfb_alu #(
        .W (AW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    assign div_take = ~alu_y[AW-1];
    assign est_ovf  = (alu_y[AW-1:EST_W-1] != {(AW - EST_W + 1){alu_y[AW-1]}});
    assign est_sat  = est_ovf ? (alu_y[AW-1] ? {1'b1, {(EST_W - 1){1'b0}}}
                                             : {1'b0, {(EST_W - 1){1'b1}}})
                              : alu_y[EST_W-1:0];
    assign cov_sat  = (alu_y[AW-1:COV_W] != '0) ? '1 : alu_y[COV_W-1:0];

    // Per-channel stores: registered read, write at the end of an update
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            x_rd_reg <= est_mem[idx];
            p_rd_reg <= cov_mem[idx];
        end
        if (state_reg == S_ADDQ)
        begin
            est_mem[idx] <= nx_reg;
            cov_mem[idx] <= cov_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= '0;
            samp_reg  <= '0;
            hit_reg   <= 1'b0;
            sum_reg   <= '0;
            rem_reg   <= '0;
            k_reg     <= '0;
            diff_reg  <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            nx_reg    <= '0;
            res_reg   <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        chan_reg <= meas_in.channel;
                        samp_reg <= meas_in.sample;
                        if (chan_ok)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            // channel beyond the bank: empty result, no update
                            res_reg   <= '{out_channel: meas_in.channel,
                                           estimate: '0, gain: '0};
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_READ:
                begin
                    hit_reg   <= vld_reg[idx];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sum_reg <= alu_y[SUM_W-1:0];
                    rem_reg <= SUM_W'(p_cur);
                    cnt_reg <= '0;
                    k_reg   <= '0;
                    if (noise_r == '0)
                    begin
                        // no divide: gain is zero or saturates at full scale
                        k_reg     <= (p_cur == '0) ? '0 : '1;
                        state_reg <= S_DIFF;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= div_take ? alu_y[SUM_W-1:0] : {rem_reg[SUM_W-2:0], 1'b0};
                    k_reg   <= {k_reg[GAIN_BITS-2:0], div_take};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(GAIN_BITS - 1))
                    begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    diff_reg  <= alu_y[DIFF_W-1:0];
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_MULX;
                end
                S_MULX:
                begin
                    acc_reg <= alu_y >>> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(GAIN_BITS - 1))
                    begin
                        state_reg <= S_ADDX;
                    end
                end
                S_ADDX:
                begin
                    nx_reg    <= est_sat;
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_MULP;
                end
                S_MULP:
                begin
                    // the top multiplier bit has weight one: add it without a shift
                    acc_reg <= (cnt_reg == CNT_W'(GAIN_BITS)) ? alu_y : (alu_y >>> 1);
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(GAIN_BITS))
                    begin
                        state_reg <= S_ADDQ;
                    end
                end
                S_ADDQ:
                begin
                    res_reg      <= '{out_channel: chan_reg, estimate: nx_reg, gain: k_reg};
                    vld_reg[idx] <= 1'b1;
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign res       = res_reg;

    `SKFB_ASSERT_HOLDS(a_div_rem_below_sum, state_reg == S_DIV, rem_reg < sum_reg, "divide remainder not below divisor")
    `SKFB_ASSERT_HOLDS(a_cov_scale_bound, state_reg == S_ADDQ, acc_reg <= AW'(p_cur), "scaled covariance exceeds old covariance")
    `SKFB_ASSERT_HOLDS(a_bad_chan_empty, state_reg == S_DONE && 32'(chan_reg) >= CHANNELS, res_reg.estimate == '0 && res_reg.gain == '0, "out-of-range channel gave nonzero result")
    `SKFB_ASSERT_NEXT(a_write_marks_valid, state_reg == S_ADDQ, state_reg == S_DONE && vld_reg[idx], "store write did not mark entry valid")

endmodule

/* design/scalar_kalman_filter_bank.sv */
// Top level of the scalar Kalman filter bank: configuration registers,
// input handshake and output word register. Depends on skfb_pkg, skfb_core.
//
//  Channel   Direction  Handshake             Word
//  meas      in         meas_valid/stall      meas_t: channel, sample
//  filt      out        filt_valid/stall      filt_t: out_channel, estimate, gain
//  cfg       in         cfg_we (no wait)      cfg_index, cfg_data
//
// An in-range word holds the core busy until its result is handed on
// (the divide is skipped when noise_r is zero); the shared adder in the core
// runs a 16-step restoring divide and two 16/17-step shift-add multiplies.
// An out-of-range channel skips the update and goes straight to its result.
// Reset clears both stores (through per-entry valid bits) and loads
// noise_r = 40.0 and process_q = 10.0. A stalled output holds the finished
// word while the core is free to take the next input word.
module scalar_kalman_filter_bank
    import skfb_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 meas_valid,
    output logic                 meas_stall,
    input  meas_t                meas,
    output logic                 filt_valid,
    input  logic                 filt_stall,
    output filt_t                filt,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [CFG_W-1:0] NOISE_R_RST   = CFG_W'(NOISE_R_INIT << FRAC_BITS);
    localparam logic [CFG_W-1:0] PROCESS_Q_RST = CFG_W'(PROCESS_Q_INIT << FRAC_BITS);

    logic [CFG_W-1:0] noise_r_reg;
    logic [CFG_W-1:0] process_q_reg;
    logic             filt_valid_reg;
    logic             filt_valid_next;
    filt_t            filt_reg;

    skfb_stat_t core_stat;
    filt_t      core_res;
    logic       meas_accept;
    logic       res_load;

    // Configuration writes; an unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_r_reg   <= NOISE_R_RST;
            process_q_reg <= PROCESS_Q_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NOISE_R:   noise_r_reg   <= cfg_data;
                REG_PROCESS_Q: process_q_reg <= cfg_data;
                default:       noise_r_reg   <= noise_r_reg;
            endcase
        end
    end

    // Hold off new words while the core iterates on one
    assign meas_stall  = core_stat.busy;
    assign meas_accept = meas_valid & ~meas_stall;

    skfb_core #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (meas_accept),
        .meas_in   (meas),
        .noise_r   (noise_r_reg),
        .process_q (process_q_reg),
        .take      (res_load),
        .stat      (core_stat),
        .res       (core_res)
    );

    // Advance the finished word into the output register when it is empty
    // or being emptied in this cycle
    assign res_load = core_stat.done & (~filt_valid_reg | ~filt_stall);

    always_comb
    begin
        filt_valid_next = filt_valid_reg;
        if (res_load)
        begin
            filt_valid_next = 1'b1;
        end
        else if (!filt_stall)
        begin
            filt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_valid_reg <= 1'b0;
        end
        else
        begin
            filt_valid_reg <= filt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            filt_reg <= core_res;
        end
    end

    assign filt_valid = filt_valid_reg;
    assign filt       = filt_reg;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for scalar_kalman_filter_bank: drives sample words and register
// writes, predicts each filtered word in a scoreboard class and checks the output channel.
// Depends on skfb_pkg and the scalar_kalman_filter_bank RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import skfb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES        = 7;
    localparam int PHASE_WORDS   = 100;
    localparam logic [CFG_W-1:0] REG_MAX = '1;

    // Scoreboard: mirrors the per-channel estimate and covariance stores, turns each
    // accepted sample into the filtered word it must produce, and checks output words
    // in order against those predictions.
    class kalman_tracker;
        logic [CFG_W-1:0]        noise_r;
        logic [CFG_W-1:0]        process_q;
        logic signed [EST_W-1:0] est_mem [CHANNELS_DEF];
        logic [COV_W-1:0]        cov_mem [CHANNELS_DEF];
        filt_t                   pending [$];
        int                      mismatches;
        int                      checked;

        function new();
            noise_r    = CFG_W'(NOISE_R_INIT) << FRAC_BITS_DEF;
            process_q  = CFG_W'(PROCESS_Q_INIT) << FRAC_BITS_DEF;
            mismatches = 0;
            checked    = 0;
            foreach (est_mem[i])
            begin
                est_mem[i] = '0;
                cov_mem[i] = '0;
            end
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
            if (idx == REG_NOISE_R)
                noise_r = val;
            else
                process_q = val;
        endfunction

        // Run one filter step on the mirrored state and queue the resulting word.
        function void accept_sample(meas_t m);
            filt_t              res;
            longint signed      z;
            longint signed      x;
            longint signed      diff;
            longint signed      nx;
            longint signed      k_s;
            logic [63:0]        p;
            logic [63:0]        sum;
            logic [63:0]        k;
            logic [63:0]        np;
            int                 ch;
            ch = int'(m.channel);
            res.out_channel = m.channel;
            if (ch >= CHANNELS_DEF)
            begin
                res.estimate = '0;
                res.gain     = '0;
                pending.push_back(res);
                return;
            end
            z   = longint'(m.sample) * (longint'(1) <<< FRAC_BITS_DEF);
            x   = longint'(est_mem[ch]);
            p   = 64'(cov_mem[ch]);
            sum = p + 64'(noise_r);
            if (sum == 0)
                k = 0;
            else
            begin
                k = (p << GAIN_BITS) / sum;
                if (k > 64'hFFFF)
                    k = 64'hFFFF;
            end
            // floor of K * (z - x) / 2^16: arithmetic shift of the signed product
            k_s  = longint'(k);
            diff = z - x;
            nx   = x + ((k_s * diff) >>> GAIN_BITS);
            if (nx > longint'(32'sh7FFF_FFFF))
                nx = longint'(32'sh7FFF_FFFF);
            if (nx < -longint'(64'h8000_0000))
                nx = -longint'(64'h8000_0000);
            np = (((64'd1 << GAIN_BITS) - k) * p) >> GAIN_BITS;
            np = np + 64'(process_q);
            if (np > 64'hFFFF_FFFF)
                np = 64'hFFFF_FFFF;
            est_mem[ch]  = EST_W'(nx);
            cov_mem[ch]  = COV_W'(np);
            res.estimate = EST_W'(nx);
            res.gain     = k[GAIN_BITS-1:0];
            pending.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one output word against the oldest prediction, field by field.
        task check_filtered(filt_t got);
            filt_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing predicted: ch %0d est %0d gain %0d",
                                          got.out_channel, got.estimate, got.gain));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.out_channel !== want.out_channel)
                report_mismatch($sformatf("out_channel got %0d want %0d",
                                          got.out_channel, want.out_channel));
            if (got.estimate !== want.estimate)
                report_mismatch($sformatf("ch %0d estimate got %0d want %0d", want.out_channel,
                                          got.estimate, want.estimate));
            if (got.gain !== want.gain)
                report_mismatch($sformatf("ch %0d gain got %0d want %0d", want.out_channel,
                                          got.gain, want.gain));
        endtask
    endclass

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 meas_valid = 1'b0;
    logic                 meas_stall;
    meas_t                meas       = '0;
    logic                 filt_valid;
    logic                 filt_stall = 1'b0;
    filt_t                filt;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = REG_NOISE_R;
    logic [CFG_W-1:0]     cfg_data   = '0;

    kalman_tracker tracker = new();

    // Idle percentages per phase; the output side reads its own each cycle.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int settings_used  = 1;
    int cycles         = 0;

    always #6 clk = ~clk;

    scalar_kalman_filter_bank DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .meas       (meas),
        .filt_valid (filt_valid),
        .filt_stall (filt_stall),
        .filt       (filt),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Output side: values read right after the edge are the ones the block saw at it,
    // so a word counts as taken when valid was high and our stall low.
    always @(posedge clk)
    begin
        if (rst_n && filt_valid && !filt_stall)
            tracker.check_filtered(filt);
        filt_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d words outstanding", $realtime, cycles,
                     tracker.pending.size());
            $display("** scalar_kalman_filter_bank: FAILED **");
            $finish;
        end
    end

    // Offer one sample word, with a random gap ahead of it, and hold it until taken.
    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp);
        meas_t w;
        w.channel = ch;
        w.sample  = smp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            meas_valid <= 1'b0;
            @(posedge clk);
        end
        meas_valid <= 1'b1;
        meas       <= w;
        @(posedge clk);
        while (meas_stall)
            @(posedge clk);
        tracker.accept_sample(w);
        words_sent++;
    endtask

    // Drop valid and hold off until every predicted word has come out.
    task automatic drain_outputs();
        meas_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    // Load both registers once the block has gone idle.
    task automatic write_regs(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] q);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NOISE_R;
        cfg_data  <= r;
        @(posedge clk);
        tracker.set_reg(REG_NOISE_R, r);
        cfg_index <= REG_PROCESS_Q;
        cfg_data  <= q;
        @(posedge clk);
        tracker.set_reg(REG_PROCESS_Q, q);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Mostly full-range samples, with the rails and small values near zero mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 16'sh7FFF;
        if (sel < 20)
            return 16'sh8000;
        if (sel < 40)
            return SAMPLE_W'(int'($urandom_range(200)) - 100);
        return SAMPLE_W'($urandom);
    endfunction

    initial
    begin
        logic [CFG_W-1:0] r_tab    [PHASES];
        logic [CFG_W-1:0] q_tab    [PHASES];
        int               send_tab [PHASES];
        int               recv_tab [PHASES];
        logic [CHAN_W-1:0] last_ch;

        r_tab    = '{31'd1, REG_MAX, 31'd1, REG_MAX, 31'd0, 31'd0, 31'd2621440};
        q_tab    = '{31'd0, REG_MAX, REG_MAX, 31'd0, 31'd0, 31'd0, 31'd655360};
        send_tab = '{0, 47, 0, 15, 0, 15, 47};
        recv_tab = '{0, 0, 47, 15, 0, 15, 0};
        last_ch  = '0;

        // Phase four takes full-range random registers, phase five small ones.
        r_tab[4] = CFG_W'($urandom);
        q_tab[4] = CFG_W'($urandom);
        if (r_tab[4] == 0)
            r_tab[4] = 31'd1;
        r_tab[5] = CFG_W'($urandom_range(1, 1 << 22));
        q_tab[5] = CFG_W'($urandom_range(0, 1 << 22));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings: sample rails on a fresh channel, a swing
        // from one rail to the other, small values, and every channel.
        send_sample(3'd0, 16'sh7FFF);
        send_sample(3'd0, 16'sh7FFF);
        send_sample(3'd0, 16'sh8000);
        send_sample(3'd0, 16'sh8000);
        send_sample(3'd0, 16'sh0000);
        send_sample(3'd0, -16'sd1);
        send_sample(3'd0, 16'sd1);
        for (int c = 1; c < CHANNELS_DEF; c++)
            send_sample(CHAN_W'(c), (c % 2) ? 16'sh8000 : 16'sh7FFF);
        send_sample(3'd7, 16'sh5555);
        send_sample(3'd7, 16'shAAAA);

        // Register extremes straight away: smallest noise drives the gain to its ceiling.
        write_regs(31'd1, REG_MAX);
        send_sample(3'd3, 16'sh7FFF);
        send_sample(3'd3, 16'sh8000);
        send_sample(3'd3, 16'sh7FFF);
        send_sample(3'd5, 16'sh0001);

        // Zero noise: the gain pins at full scale while the covariance decays, then
        // drops to zero once covariance and noise are both zero.
        write_regs(31'd0, 31'd0);
        send_sample(3'd6, 16'sh7FFF);
        send_sample(3'd6, 16'sh8000);
        send_sample(3'd6, 16'sh1234);
        send_sample(3'd6, 16'sh7FFF);

        // Random phases: each with its own register setting and idle pattern.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_regs(r_tab[ph], q_tab[ph]);
            send_idle_pct  = send_tab[ph];
            recv_stall_pct = recv_tab[ph];
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Stay on one channel now and then so its filter converges.
                if ($urandom_range(99) >= 30)
                    last_ch = CHAN_W'($urandom);
                send_sample(last_ch, pick_sample());
                // Halfway through the stalled phase, let the pipeline empty out.
                if (ph == 2 && n == PHASE_WORDS / 2)
                    drain_outputs();
            end
        end

        meas_valid <= 1'b0;
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending.size() != 0)
            tracker.report_mismatch($sformatf("%0d predicted words never came out",
                                              tracker.pending.size()));

        $display("Run covered %0d sample words over %0d channels and %0d register settings;",
                 words_sent, CHANNELS_DEF, settings_used);
        $display("%0d filtered words checked, %0d mismatches.", tracker.checked,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("** scalar_kalman_filter_bank: PASSED **");
        else
            $display("** scalar_kalman_filter_bank: FAILED **");
        $finish;
    end
endmodule
